@@ design/itbs_pkg.sv @@
// Shared types and constants for the integer to base string converter.
// No dependencies; imported by every module of the block.
package itbs_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_BUFFER = 1024;

  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int VALUE_W    = 32;
  localparam int BCD_W      = 4 * DEC_DIGITS;
  localparam int NDIG_W     = 4;
  localparam int CNT_W      = 5;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] HEX_OFFSET  = 8'd87;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0] RADIX_DEC   = 4'd10;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef logic [3:0] digit_t;

  // One conversion ready to print: digits least significant first
  typedef struct packed {
    logic                          neg;
    digit_t [DEC_DIGITS-1:0]       digits;
    logic [NDIG_W-1:0]             ndig;
    logic [5:0]                    pad;
    logic [5:0]                    len;
    logic [5:0]                    emit;
  } job_t;

  function automatic logic [7:0] digit_char(input digit_t d);
    if (d < RADIX_DEC) begin
      return ASCII_ZERO + {4'd0, d};
    end
    return HEX_OFFSET + {4'd0, d};
  endfunction

endpackage

@@ design/itbs_front.sv @@
// Front end: accepts a word, classifies sign and base, runs the serial
// binary to BCD conversion and pushes a print job. Depends on itbs_pkg.
module itbs_front import itbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] value,
  input  logic        base_is_hex,
  input  logic [5:0]  field_width,
  input  logic [10:0] buffer_space,
  output logic        push,
  input  logic        full,
  output job_t        job
);

  front_state_t state, state_next;

  logic               neg;
  logic               hex;
  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] sh;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;
  logic [5:0]         width;
  logic [10:0]        space;

  logic               accept;
  logic [VALUE_W-1:0] mag_in;
  logic [BCD_W-1:0]   bcd_adj;
  digit_t [DEC_DIGITS-1:0] dig;
  logic [NDIG_W-1:0]  ndig;
  logic [5:0]         wadj;
  logic [5:0]         pad;
  logic [5:0]         len;
  logic [10:0]        space_m1;
  logic [5:0]         emit;

  assign accept = in_valid && in_ready;
  assign mag_in = (cmd && value[VALUE_W-1]) ? (~value + 32'd1) : value;

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (hex) begin
        dig[i] = (i < HEX_DIGITS) ? mag[4*(i % HEX_DIGITS) +: 4] : 4'd0;
      end else begin
        dig[i] = bcd[4*i +: 4];
      end
    end
    ndig = NDIG_W'(1);
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        ndig = NDIG_W'(i + 1);
      end
    end
    // The sign takes one place of the minimum width
    if (neg) begin
      wadj = (width == 6'd0) ? 6'd0 : width - 6'd1;
    end else begin
      wadj = width;
    end
    pad = (wadj > {2'd0, ndig}) ? wadj - {2'd0, ndig} : 6'd0;
    len = {5'd0, neg} + pad + {2'd0, ndig};
    space_m1 = space - 11'd1;
    if (space == 11'd0) begin
      emit = 6'd0;
    end else if ({5'd0, len} > space_m1) begin
      emit = space_m1[5:0];
    end else begin
      emit = len;
    end
  end

  always_comb begin
    job.neg    = neg;
    job.digits = dig;
    job.ndig   = ndig;
    job.pad    = pad;
    job.len    = len;
    job.emit   = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = base_is_hex ? F_PUSH : F_CONV;
        end
      end
      F_CONV: begin
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        push = !full;
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg   <= cmd && value[VALUE_W-1];
      hex   <= base_is_hex;
      mag   <= mag_in;
      sh    <= mag_in;
      bcd   <= '0;
      cnt   <= '0;
      width <= (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
      space <= (buffer_space > 11'(MAX_BUFFER)) ? 11'(MAX_BUFFER) : buffer_space;
    end else if (state == F_CONV) begin
      bcd <= {bcd_adj[BCD_W-2:0], sh[VALUE_W-1]};
      sh  <= {sh[VALUE_W-2:0], 1'b0};
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

@@ design/itbs_queue.sv @@
// Two-entry job queue between the converter and the character emitter.
// Depends on itbs_pkg for the job type and depth.
module itbs_queue import itbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

@@ design/itbs_back.sv @@
// Back end: walks the head job one character a cycle into the output
// register while the output is not stalled. Depends on itbs_pkg.
module itbs_back import itbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  job_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       last,
  output logic [5:0] total_length
);

  logic [5:0]        idx;
  logic              load;
  logic              is_last;
  logic [5:0]        j;
  logic [5:0]        k;
  logic [NDIG_W-1:0] sel;
  logic [7:0]        ch;

  assign load    = !out_valid || out_ready;
  assign pop     = load && !empty && is_last;
  assign is_last = (head.emit == 6'd0) || (idx + 6'd1 == head.emit);

  always_comb begin
    j   = idx - {5'd0, head.neg};
    k   = j - head.pad;
    sel = head.ndig - NDIG_W'(1) - k[NDIG_W-1:0];
    if (head.emit == 6'd0) begin
      ch = 8'd0;
    end else if (head.neg && idx == 6'd0) begin
      ch = ASCII_MINUS;
    end else if (j < head.pad) begin
      ch = ASCII_ZERO;
    end else if (sel < NDIG_W'(DEC_DIGITS)) begin
      ch = digit_char(head.digits[sel]);
    end else begin
      ch = ASCII_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) begin
        idx <= is_last ? 6'd0 : idx + 6'd1;
      end
    end
  end

  // Hold the payload while a result waits
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_char     <= ch;
      char_valid   <= (head.emit != 6'd0);
      last         <= is_last;
      total_length <= head.len;
    end
  end

endmodule

@@ design/integer_to_base_string.sv @@
// Top level of the integer to base string converter: front end, job queue
// and character emitter. Depends on itbs_pkg, itbs_front, itbs_queue, itbs_back.
//
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | cmd, value, base_is_hex, field_width, buffer_space
//   output  | out_valid / out_ready| out_char, char_valid, last, total_length
//
// A decimal word runs serial BCD shifts over all bits of the value in one
// shared add-three step, between accept and push; a hex word goes straight
// from accept to push. The emitter sends one character a cycle while the
// output is not stalled. Reset clears the state machine, queue pointers and
// output valid. A stalled output holds the emitter; the two-entry queue lets
// the front end keep converting meanwhile.
module integer_to_base_string import itbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] value,
  input  logic        base_is_hex,
  input  logic [5:0]  field_width,
  input  logic [10:0] buffer_space,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        last,
  output logic [5:0]  total_length
);

  logic push;
  logic full;
  logic pop;
  logic empty;
  job_t push_job;
  job_t head;

  itbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .value        (value),
    .base_is_hex  (base_is_hex),
    .field_width  (field_width),
    .buffer_space (buffer_space),
    .push         (push),
    .full         (full),
    .job          (push_job)
  );

  itbs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  itbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .char_valid   (char_valid),
    .last         (last),
    .total_length (total_length)
  );

endmodule
